// File: rtl/core/spsfl_pkg.sv
// Shared types and constants for the stereo PCM smooth/fade/limit block.
`default_nettype none
package spsfl_pkg;

  // Sample and port widths
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 22;
  localparam int TDATA_W  = 2 * SAMPLE_W;

  // Soft knee: above KNEE_START the excess is divided by 6 through a
  // reciprocal multiply (43691 / 2^18), exact for excess below 2^17.
  localparam logic [SAMPLE_W-1:0] KNEE_START = 16'd26000;
  localparam int                  KNEE_T_W   = 13;
  localparam logic [15:0]         KNEE_RECIP = 16'd43691;
  localparam int                  KNEE_SHIFT = 18;
  localparam int                  KPROD_W    = KNEE_T_W + 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture input transaction, update clip state
    logic mul;       // fade multiply, load divider
    logic div_step;  // one restoring-divider iteration
    logic knee_mul;  // knee excess times reciprocal
    logic knee_fin;  // knee add, sign restore
    logic out_load;  // move result into output register
  } spsfl_cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/spsfl_ctrl.sv
// Sequencer for one frame: accept, multiply, divide, knee, hand off.
`default_nettype none
module spsfl_ctrl #(
  parameter int PW = 24
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire                     out_tready,
  output spsfl_pkg::spsfl_cmd_t   cmd
);
  import spsfl_pkg::*;

  localparam int CNTW = (PW > 1) ? $clog2(PW) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_KN1  = 3'd3;
  localparam logic [2:0] S_KN2  = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            ovalid_r, ovalid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNTW'(PW - 1)) begin
          state_nxt = S_KN1;
        end
      end
      S_KN1: begin
        cmd.knee_mul = 1'b1;
        state_nxt    = S_KN2;
      end
      S_KN2: begin
        cmd.knee_fin = 1'b1;
        state_nxt    = S_HOLD;
      end
      S_HOLD: begin
        if (!ovalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.out_load) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

endmodule
`default_nettype wire

// File: rtl/core/spsfl_dp.sv
// Datapath: clip state, smoothing, fade multiply/divide, soft knee, output register.
`default_nettype none
module spsfl_dp #(
  parameter int FADE_MAX   = 128,
  parameter int MAX_FRAMES = 2097152,
  parameter int FW         = 8,
  parameter int PW         = 24
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  spsfl_pkg::spsfl_cmd_t            cmd,
  input  wire [spsfl_pkg::TDATA_W-1:0]     in_tdata,
  input  wire                              cfg_wr_en,
  input  wire [spsfl_pkg::CFG_W-1:0]       cfg_wr_data,
  output logic [spsfl_pkg::TDATA_W-1:0]    out_tdata,
  output logic                             out_tlast
);
  import spsfl_pkg::*;

  localparam int IW  = $clog2(MAX_FRAMES);
  localparam int CW0 = $clog2(MAX_FRAMES + 1);
  localparam int EW  = ((CW0 > CFG_W) ? CW0 : CFG_W) + 1;

  // Configuration and clip state
  logic [CFG_W-1:0]    frame_count_r;
  logic [IW-1:0]       idx_r;
  logic [SAMPLE_W-1:0] prev_r [2];

  // Per-frame working registers
  logic [16:0]         v_r     [2];
  logic                sign_r  [2];
  logic [PW-1:0]       dvd_r   [2];
  logic [FW-1:0]       rem_r   [2];
  logic [KPROD_W-1:0]  kprod_r [2];
  logic                over_r  [2];
  logic [SAMPLE_W-1:0] res_r   [2];
  logic [FW-1:0]       factor_r, divisor_r;
  logic                last_r;

  // Output register
  logic [TDATA_W-1:0]  odata_r;
  logic                olast_r;

  // Count clamp, fade length and fade factor
  logic [EW-1:0] cnt_ext, count_c, half_c, fade_ext, idx_ext, remain_c;
  logic [FW-1:0] fade_c, factor_c, divisor_c;
  logic          in_head, in_tail, last_c;

  always_comb begin
    cnt_ext = EW'(frame_count_r);
    if (cnt_ext == '0) begin
      count_c = EW'(1);
    end else if (cnt_ext > EW'(MAX_FRAMES)) begin
      count_c = EW'(MAX_FRAMES);
    end else begin
      count_c = cnt_ext;
    end
    half_c   = count_c >> 1;
    fade_ext = (half_c > EW'(FADE_MAX)) ? EW'(FADE_MAX) : half_c;
    fade_c   = fade_ext[FW-1:0];
    idx_ext  = EW'(idx_r);
    remain_c = (idx_ext < count_c) ? (count_c - idx_ext) : '0;
    in_head  = (fade_ext != '0) && (idx_ext < fade_ext);
    in_tail  = (fade_ext != '0) && ((idx_ext + fade_ext) >= count_c);
    last_c   = (idx_ext + EW'(1)) >= count_c;
    if (in_head) begin
      factor_c  = idx_ext[FW-1:0];
      divisor_c = fade_c;
    end else if (in_tail) begin
      factor_c  = remain_c[FW-1:0];
      divisor_c = fade_c;
    end else begin
      factor_c  = FW'(1);
      divisor_c = FW'(1);
    end
  end

  // Smoothing: (3x + prev) / 4, truncated toward zero
  logic [SAMPLE_W-1:0] x_c  [2];
  logic [18:0]         sum_c [2];
  logic [18:0]         adj_c [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      x_c[k]   = in_tdata[k*SAMPLE_W +: SAMPLE_W];
      sum_c[k] = {{3{x_c[k][15]}}, x_c[k]} + {{2{x_c[k][15]}}, x_c[k], 1'b0}
               + {{3{prev_r[k][15]}}, prev_r[k]};
      adj_c[k] = sum_c[k] + (sum_c[k][18] ? 19'd3 : 19'd0);
    end
  end

  // Fade multiply on magnitude, divider trial, knee terms
  logic [16:0]          mag_c   [2];
  logic [FW:0]          trial_c [2];
  logic                 qbit_c  [2];
  logic [SAMPLE_W-1:0]  q_c     [2];
  logic [KNEE_T_W-1:0]  t_c     [2];
  logic [SAMPLE_W-1:0]  kmag_c  [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      mag_c[k]   = v_r[k][16] ? (~v_r[k] + 17'd1) : v_r[k];
      trial_c[k] = {rem_r[k], dvd_r[k][PW-1]};
      qbit_c[k]  = (trial_c[k] >= {1'b0, divisor_r});
      q_c[k]     = dvd_r[k][SAMPLE_W-1:0];
      t_c[k]     = KNEE_T_W'(q_c[k] - KNEE_START);
      kmag_c[k]  = over_r[k]
                 ? (KNEE_START + SAMPLE_W'(kprod_r[k][KPROD_W-1:KNEE_SHIFT]))
                 : q_c[k];
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      frame_count_r <= cfg_wr_data;
    end
  end

  // Clip position and previous raw samples
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      for (int k = 0; k < 2; k++) begin
        prev_r[k] <= '0;
      end
    end else if (cmd.load) begin
      if (last_c) begin
        idx_r <= '0;
        for (int k = 0; k < 2; k++) begin
          prev_r[k] <= '0;
        end
      end else begin
        idx_r <= idx_r + 1'b1;
        for (int k = 0; k < 2; k++) begin
          prev_r[k] <= x_c[k];
        end
      end
    end
  end

  // Per-frame pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      factor_r  <= factor_c;
      divisor_r <= divisor_c;
      last_r    <= last_c;
    end
    for (int k = 0; k < 2; k++) begin
      if (cmd.load) begin
        v_r[k] <= adj_c[k][18:2];
      end
      if (cmd.mul) begin
        sign_r[k] <= v_r[k][16];
        dvd_r[k]  <= {{FW{1'b0}}, mag_c[k][SAMPLE_W-1:0]} * {{SAMPLE_W{1'b0}}, factor_r};
        rem_r[k]  <= '0;
      end else if (cmd.div_step) begin
        dvd_r[k] <= {dvd_r[k][PW-2:0], qbit_c[k]};
        rem_r[k] <= qbit_c[k] ? FW'(trial_c[k] - {1'b0, divisor_r}) : trial_c[k][FW-1:0];
      end
      if (cmd.knee_mul) begin
        over_r[k]  <= (q_c[k] > KNEE_START);
        kprod_r[k] <= {{16{1'b0}}, t_c[k]} * {{KNEE_T_W{1'b0}}, KNEE_RECIP};
      end
      if (cmd.knee_fin) begin
        res_r[k] <= sign_r[k] ? (~kmag_c[k] + 1'b1) : kmag_c[k];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      odata_r <= {res_r[1], res_r[0]};
      olast_r <= last_r;
    end
  end

  assign out_tdata = odata_r;
  assign out_tlast = olast_r;

endmodule
`default_nettype wire

// File: rtl/core/stereo_pcm_smooth_fade_limit_unit.sv
// Top level of the stereo PCM smooth/fade/limit block.
//
// Usage: write the clip length (frames) on cfg_wr_data with cfg_wr_en while the
// block is idle, then stream one stereo frame per input transaction:
// in_tdata = {right_in, left_in}. Each frame gives one output transaction:
// out_tdata = {right_out, left_out}, out_tlast high on the final frame of the
// clip. Each channel is smoothed, faded in and out at the clip edges, and
// passed through a soft knee above magnitude 26000.
// Flow: one frame is handled at a time. A frame passes through the MUL, DIV,
// KN1, KN2 and HOLD states before the next is accepted; in DIV the fade divider
// retires one quotient bit per cycle, PW = 16 + clog2(FADE_MAX + 1) bits in all.
// Output becomes valid once the result is loaded into the output register.
// A one-entry output register lets the next frame be accepted and processed
// while a result waits; if the receiver still stalls when that frame is done,
// the block holds it and deasserts in_tready until the output drains.
// Reset (rst_n low, synchronous) sets the clip length to 1, clears the frame
// position and the previous samples, and empties the output register.
`default_nettype none
module stereo_pcm_smooth_fade_limit_unit #(
  parameter int FADE_MAX   = 128,
  parameter int MAX_FRAMES = 2097152
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // fields from bit 0: left_in[15:0], right_in[31:16]
  input  wire [spsfl_pkg::TDATA_W-1:0]     in_tdata,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // fields from bit 0: left_out[15:0], right_out[31:16]
  output logic [spsfl_pkg::TDATA_W-1:0]    out_tdata,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  input  wire                              cfg_wr_en,
  input  wire [spsfl_pkg::CFG_W-1:0]       cfg_wr_data
);
  import spsfl_pkg::*;

  localparam int FW = $clog2(FADE_MAX + 1);
  localparam int PW = SAMPLE_W + FW;

  spsfl_cmd_t cmd;

  spsfl_ctrl #(
    .PW(PW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spsfl_dp #(
    .FADE_MAX   (FADE_MAX),
    .MAX_FRAMES (MAX_FRAMES),
    .FW         (FW),
    .PW         (PW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
`default_nettype wire
